// File: hw/rtl/sts_pkg.sv
package sts_pkg;

  localparam int unsigned OFF_BITS = 24;
  localparam int unsigned POS_BITS = 16;
  localparam int unsigned MAX_TOK  = 4;
  localparam int unsigned NUM_KW   = 14;

  localparam logic [OFF_BITS-1:0] OFF_MAX = {OFF_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [5:0] KIND_LPAREN  = 6'd13;
  localparam logic [5:0] KIND_RPAREN  = 6'd14;
  localparam logic [5:0] KIND_LBRACE  = 6'd15;
  localparam logic [5:0] KIND_RBRACE  = 6'd16;
  localparam logic [5:0] KIND_SEMI    = 6'd17;
  localparam logic [5:0] KIND_COMMA   = 6'd18;
  localparam logic [5:0] KIND_PLUS    = 6'd19;
  localparam logic [5:0] KIND_COLON   = 6'd20;
  localparam logic [5:0] KIND_ASSIGN  = 6'd21;
  localparam logic [5:0] KIND_BANG    = 6'd23;
  localparam logic [5:0] KIND_LT      = 6'd25;
  localparam logic [5:0] KIND_GT      = 6'd27;
  localparam logic [5:0] KIND_ANDAND  = 6'd29;
  localparam logic [5:0] KIND_OROR    = 6'd30;
  localparam logic [5:0] KIND_ARROW   = 6'd31;
  localparam logic [5:0] KIND_STRLIT  = 6'd32;
  localparam logic [5:0] KIND_IDENT   = 6'd33;
  localparam logic [5:0] KIND_INT     = 6'd34;
  localparam logic [5:0] KIND_FLOAT   = 6'd35;
  localparam logic [5:0] KIND_UNKNOWN = 6'd36;
  localparam logic [5:0] KIND_EOF     = 6'd37;

  // keyword text, right aligned, first character in the highest used byte
  localparam logic [NUM_KW-1:0][47:0] KW_TEXT = '{
    48'h0000_6d65_6f77, 48'h0000_7363_616e, 48'h0070_7269_6e74,
    48'h0066_616c_7365, 48'h0000_7472_7565, 48'h0000_626f_6f6c,
    48'h7374_7269_6e67, 48'h0066_6c6f_6174, 48'h0000_0069_6e74,
    48'h0077_6869_6c65, 48'h0000_656c_7365, 48'h0000_0000_6966,
    48'h7265_7475_726e, 48'h0000_0000_666e};
  localparam logic [NUM_KW-1:0][2:0] KW_LEN = '{
    3'd4, 3'd4, 3'd5, 3'd5, 3'd4, 3'd4, 3'd6,
    3'd5, 3'd3, 3'd5, 3'd4, 3'd2, 3'd6, 3'd2};
  localparam logic [NUM_KW-1:0][5:0] KW_KIND = '{
    6'd12, 6'd11, 6'd10, 6'd9, 6'd9, 6'd8, 6'd7,
    6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1, 6'd0};

  typedef struct packed {
    logic [5:0]          kind;
    logic [OFF_BITS-1:0] start;
    logic [OFF_BITS-1:0] length;
    logic [POS_BITS-1:0] line;
    logic [POS_BITS-1:0] column;
    logic                unterminated;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOK-1:0] tk;
    logic [2:0]         cnt;
  } bundle_t;

  function automatic logic [OFF_BITS-1:0] span(input logic [OFF_BITS-1:0] a,
                                               input logic [OFF_BITS-1:0] b,
                                               input logic k);
    logic [OFF_BITS:0] bk;
    bk = {1'b0, b} + {{OFF_BITS{1'b0}}, k};
    if ({1'b0, a} < bk) return '0;
    return a - b - {{(OFF_BITS-1){1'b0}}, k};
  endfunction

  function automatic logic [5:0] kw_kind(input logic [47:0] kb,
                                         input logic [OFF_BITS-1:0] len);
    logic [5:0] k;
    k = KIND_IDENT;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (len == OFF_BITS'(KW_LEN[i]) && kb == KW_TEXT[i]) k = KW_KIND[i];
    end
    return k;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

// File: hw/rtl/sts_front.sv
module sts_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_value_i,
  input  logic             has_byte_i,
  input  logic             is_last_i,
  output logic             push_o,
  output sts_pkg::bundle_t push_data_o,
  input  logic             q_ready_i
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_CMT, M_SLASH,
    M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_BAR, M_MINUS
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic [47:0]                  kb_q, kb_d;
  logic [sts_pkg::OFF_BITS-1:0] ts_q, ts_d, off_q, off_d;
  logic [sts_pkg::POS_BITS-1:0] ln_q, ln_d, cl_q, cl_d, sc_q, sc_d;
  sts_pkg::tok_t [sts_pkg::MAX_TOK-1:0] tk;
  logic [2:0]                   n;
  logic                         accept;

  function automatic logic [sts_pkg::OFF_BITS-1:0] inc_off(
      input logic [sts_pkg::OFF_BITS-1:0] v);
    return (v < sts_pkg::OFF_MAX) ? v + 1'b1 : v;
  endfunction

  function automatic logic [sts_pkg::POS_BITS-1:0] inc_pos(
      input logic [sts_pkg::POS_BITS-1:0] v);
    return (v < sts_pkg::POS_MAX) ? v + 1'b1 : v;
  endfunction

  function automatic logic [5:0] single_kind(input mode_e m);
    unique case (m)
      M_EQ:    return sts_pkg::KIND_ASSIGN;
      M_BANG:  return sts_pkg::KIND_BANG;
      M_LT:    return sts_pkg::KIND_LT;
      M_GT:    return sts_pkg::KIND_GT;
      default: return sts_pkg::KIND_UNKNOWN;
    endcase
  endfunction

  assign accept     = in_valid_i && q_ready_i;
  assign in_ready_o = q_ready_i;

  always_comb begin
    mode_e                        m;
    logic [47:0]                  kb;
    logic [sts_pkg::OFF_BITS-1:0] ts, off, dot;
    logic [sts_pkg::POS_BITS-1:0] ln, cl, sc;
    logic                         disp;
    logic [7:0]                   c;
    m = mode_q; kb = kb_q; ts = ts_q; off = off_q; ln = ln_q; cl = cl_q; sc = sc_q;
    tk = '0;
    n = '0;
    disp = 1'b0;
    dot = '0;
    c = byte_value_i;

    if (has_byte_i) begin
      unique case (m)
        M_IDLE: disp = 1'b1;
        M_IDENT: begin
          if (sts_pkg::is_letter(c) || sts_pkg::is_dig(c)) begin
            kb = {kb[39:0], c};
            off = inc_off(off); cl = inc_pos(cl);
          end else begin
            tk[n[1:0]] = '{sts_pkg::kw_kind(kb, sts_pkg::span(off, ts, 1'b0)), ts,
                           sts_pkg::span(off, ts, 1'b0), ln, cl, 1'b0};
            n = n + 3'd1;
            disp = 1'b1;
          end
        end
        M_INT: begin
          if (sts_pkg::is_dig(c)) begin
            off = inc_off(off); cl = inc_pos(cl);
          end else if (c == ".") begin
            sc = cl;
            off = inc_off(off); cl = inc_pos(cl);
            m = M_DOT;
          end else begin
            tk[n[1:0]] = '{sts_pkg::KIND_INT, ts, sts_pkg::span(off, ts, 1'b0), ln, cl, 1'b0};
            n = n + 3'd1;
            disp = 1'b1;
          end
        end
        M_DOT: begin
          if (sts_pkg::is_dig(c)) begin
            off = inc_off(off); cl = inc_pos(cl);
            m = M_FRAC;
          end else begin
            dot = (off > ts) ? off - 1'b1 : off;
            tk[n[1:0]] = '{sts_pkg::KIND_INT, ts, sts_pkg::span(dot, ts, 1'b0), ln, sc, 1'b0};
            n = n + 3'd1;
            tk[n[1:0]] = '{sts_pkg::KIND_UNKNOWN, dot, sts_pkg::OFF_BITS'(1), ln, cl, 1'b0};
            n = n + 3'd1;
            disp = 1'b1;
          end
        end
        M_FRAC: begin
          if (sts_pkg::is_dig(c)) begin
            off = inc_off(off); cl = inc_pos(cl);
          end else begin
            tk[n[1:0]] = '{sts_pkg::KIND_FLOAT, ts, sts_pkg::span(off, ts, 1'b0), ln, cl, 1'b0};
            n = n + 3'd1;
            disp = 1'b1;
          end
        end
        M_STR: begin
          if (c == "\"") begin
            tk[n[1:0]].length = sts_pkg::span(off, ts, 1'b1);
            off = inc_off(off); cl = inc_pos(cl);
            tk[n[1:0]].kind = sts_pkg::KIND_STRLIT;
            tk[n[1:0]].start = inc_off(ts);
            tk[n[1:0]].line = ln;
            tk[n[1:0]].column = cl;
            tk[n[1:0]].unterminated = 1'b0;
            n = n + 3'd1;
            m = M_IDLE;
          end else if (c == 8'h0a) begin
            off = inc_off(off); ln = inc_pos(ln); cl = sts_pkg::POS_BITS'(1);
          end else begin
            off = inc_off(off); cl = inc_pos(cl);
          end
        end
        M_CMT: begin
          if (c != 8'h0a) begin
            off = inc_off(off); cl = inc_pos(cl);
          end else begin
            disp = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            off = inc_off(off); cl = inc_pos(cl);
            m = M_CMT;
          end else begin
            tk[n[1:0]] = '{sts_pkg::KIND_UNKNOWN, ts, sts_pkg::span(off, ts, 1'b0), ln, cl,
                           1'b0};
            n = n + 3'd1;
            disp = 1'b1;
          end
        end
        M_EQ, M_BANG, M_LT, M_GT: begin
          if (c == "=") begin
            off = inc_off(off); cl = inc_pos(cl);
            tk[n[1:0]] = '{single_kind(m) + 6'd1, ts, sts_pkg::span(off, ts, 1'b0), ln, cl,
                           1'b0};
            n = n + 3'd1;
            m = M_IDLE;
          end else begin
            tk[n[1:0]] = '{single_kind(m), ts, sts_pkg::span(off, ts, 1'b0), ln, cl, 1'b0};
            n = n + 3'd1;
            disp = 1'b1;
          end
        end
        M_AMP, M_BAR, M_MINUS: begin
          if ((m == M_AMP && c == "&") || (m == M_BAR && c == "|") ||
              (m == M_MINUS && c == ">")) begin
            off = inc_off(off); cl = inc_pos(cl);
            tk[n[1:0]] = '{(m == M_AMP) ? sts_pkg::KIND_ANDAND :
                           (m == M_BAR) ? sts_pkg::KIND_OROR : sts_pkg::KIND_ARROW,
                           ts, sts_pkg::span(off, ts, 1'b0), ln, cl, 1'b0};
            n = n + 3'd1;
            m = M_IDLE;
          end else begin
            tk[n[1:0]] = '{sts_pkg::KIND_UNKNOWN, ts, sts_pkg::span(off, ts, 1'b0), ln, cl,
                           1'b0};
            n = n + 3'd1;
            disp = 1'b1;
          end
        end
        default: disp = 1'b1;
      endcase

      if (disp) begin
        m = M_IDLE;
        unique case (c)
          " ", 8'h0d, 8'h09: begin
            off = inc_off(off); cl = inc_pos(cl);
          end
          8'h0a: begin
            off = inc_off(off); ln = inc_pos(ln); cl = sts_pkg::POS_BITS'(1);
          end
          "(", ")", "{", "}", ";", ",", "+", ":": begin
            ts = off;
            off = inc_off(off); cl = inc_pos(cl);
            tk[n[1:0]].kind = (c == "(") ? sts_pkg::KIND_LPAREN :
                              (c == ")") ? sts_pkg::KIND_RPAREN :
                              (c == "{") ? sts_pkg::KIND_LBRACE :
                              (c == "}") ? sts_pkg::KIND_RBRACE :
                              (c == ";") ? sts_pkg::KIND_SEMI :
                              (c == ",") ? sts_pkg::KIND_COMMA :
                              (c == "+") ? sts_pkg::KIND_PLUS : sts_pkg::KIND_COLON;
            tk[n[1:0]].start = ts;
            tk[n[1:0]].length = sts_pkg::span(off, ts, 1'b0);
            tk[n[1:0]].line = ln;
            tk[n[1:0]].column = cl;
            tk[n[1:0]].unterminated = 1'b0;
            n = n + 3'd1;
          end
          "=", "!", "<", ">", "&", "|", "-", "/", "\"": begin
            ts = off;
            off = inc_off(off); cl = inc_pos(cl);
            m = (c == "=") ? M_EQ : (c == "!") ? M_BANG : (c == "<") ? M_LT :
                (c == ">") ? M_GT : (c == "&") ? M_AMP : (c == "|") ? M_BAR :
                (c == "-") ? M_MINUS : (c == "/") ? M_SLASH : M_STR;
          end
          default: begin
            ts = off;
            off = inc_off(off); cl = inc_pos(cl);
            if (sts_pkg::is_letter(c)) begin
              kb = {40'd0, c};
              m = M_IDENT;
            end else if (sts_pkg::is_dig(c)) begin
              m = M_INT;
            end else begin
              tk[n[1:0]] = '{sts_pkg::KIND_UNKNOWN, ts, sts_pkg::span(off, ts, 1'b0), ln, cl,
                             1'b0};
              n = n + 3'd1;
            end
          end
        endcase
      end
    end

    if (is_last_i) begin
      unique case (m)
        M_IDENT: begin
          tk[n[1:0]] = '{sts_pkg::kw_kind(kb, sts_pkg::span(off, ts, 1'b0)), ts,
                         sts_pkg::span(off, ts, 1'b0), ln, cl, 1'b0};
          n = n + 3'd1;
        end
        M_INT, M_FRAC, M_SLASH, M_AMP, M_BAR, M_MINUS, M_EQ, M_BANG, M_LT, M_GT: begin
          tk[n[1:0]] = '{(m == M_INT) ? sts_pkg::KIND_INT :
                         (m == M_FRAC) ? sts_pkg::KIND_FLOAT : single_kind(m),
                         ts, sts_pkg::span(off, ts, 1'b0), ln, cl, 1'b0};
          n = n + 3'd1;
        end
        M_DOT: begin
          dot = (off > ts) ? off - 1'b1 : off;
          tk[n[1:0]] = '{sts_pkg::KIND_INT, ts, sts_pkg::span(dot, ts, 1'b0), ln, sc, 1'b0};
          n = n + 3'd1;
          tk[n[1:0]] = '{sts_pkg::KIND_UNKNOWN, dot, sts_pkg::OFF_BITS'(1), ln, cl, 1'b0};
          n = n + 3'd1;
        end
        M_STR: begin
          tk[n[1:0]] = '{sts_pkg::KIND_UNKNOWN, inc_off(ts), sts_pkg::span(off, ts, 1'b1),
                         ln, cl, 1'b1};
          n = n + 3'd1;
        end
        default: ;
      endcase
      tk[n[1:0]] = '{sts_pkg::KIND_EOF, off, '0, ln, cl, 1'b0};
      n = n + 3'd1;
      // next source starts from the reset state
      m = M_IDLE; kb = '0; ts = '0; off = '0;
      ln = sts_pkg::POS_BITS'(1); cl = sts_pkg::POS_BITS'(1); sc = sts_pkg::POS_BITS'(1);
    end

    mode_d = m; kb_d = kb; ts_d = ts; off_d = off; ln_d = ln; cl_d = cl; sc_d = sc;
  end

  assign push_o          = accept && (n != 3'd0);
  assign push_data_o.tk  = tk;
  assign push_data_o.cnt = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      kb_q   <= '0;
      ts_q   <= '0;
      off_q  <= '0;
      ln_q   <= sts_pkg::POS_BITS'(1);
      cl_q   <= sts_pkg::POS_BITS'(1);
      sc_q   <= sts_pkg::POS_BITS'(1);
    end else if (accept) begin
      mode_q <= mode_d;
      kb_q   <= kb_d;
      ts_q   <= ts_d;
      off_q  <= off_d;
      ln_q   <= ln_d;
      cl_q   <= cl_d;
      sc_q   <= sc_d;
    end
  end

endmodule

// File: hw/rtl/sts_queue.sv
module sts_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sts_pkg::bundle_t push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sts_pkg::bundle_t head_o
);

  sts_pkg::bundle_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: hw/rtl/sts_back.sv
module sts_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  sts_pkg::bundle_t      head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sts_pkg::tok_t         out_tok_o,
  output logic                  out_last_o
);

  logic [1:0] idx_q;
  logic       fire;

  assign out_valid_o = q_valid_i;
  assign out_tok_o   = head_i.tk[idx_q];
  assign out_last_o  = ({1'b0, idx_q} == head_i.cnt - 3'd1);
  assign fire        = q_valid_i && out_ready_i;
  assign pop_o       = fire && out_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= out_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// File: hw/rtl/source_token_scanner.sv
// Byte-serial source scanner. One source byte per input transaction (tuser = byte present,
// tlast = end of source); each transaction yields zero to four token transactions, the last
// flagged by tlast, and end of source adds an end-of-file token and resets all counters.
// Input is taken at one per cycle whenever the two-entry token queue has room; output
// drains one token per cycle while tready is high, and a byte's queue entry frees after its last token.
module source_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tuser_i,   // has_byte
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // kind[5:0] start[29:6] length[53:30]
                                        // line[69:54] column[85:70] zero[87:86]
  output logic        m_axis_tuser_o,   // unterminated
  output logic        m_axis_tlast_o    // last_result
);

  logic             push, q_ready, q_valid, pop;
  sts_pkg::bundle_t push_data, head;
  sts_pkg::tok_t    tok;

  sts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .byte_value_i (s_axis_tdata_i),
    .has_byte_i   (s_axis_tuser_i),
    .is_last_i    (s_axis_tlast_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .q_ready_i    (q_ready)
  );

  sts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  sts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tok_o   (tok),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, tok.column, tok.line, tok.length, tok.start, tok.kind};
  assign m_axis_tuser_o = tok.unterminated;

endmodule

// File: hw/rtl/sts_checker.sv
module sts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [87:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[5:0] <= 6'd37)
    else $error("token kind out of range");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[69:54] != 16'd0 && m_axis_tdata_o[85:70] != 16'd0)
    else $error("line or column is zero");

  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[5:0] == 6'd37 |->
      m_axis_tlast_o && m_axis_tdata_o[53:30] == 24'd0 && !m_axis_tuser_o)
    else $error("malformed end-of-file token");

endmodule

bind source_token_scanner sts_checker u_sts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
